// ----- design/twf_pkg.sv -----
package twf_pkg;

	localparam int DEPTH = 256;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int STAMP_W = 64;
	localparam int WIN_W = 32;
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000);
	localparam logic [STAMP_W-1:0] SIGN_MASK = {1'b1, {(STAMP_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ACT_ENQ   = 2'd0,
		ACT_DEQ   = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_PURGE = 2'd3
	} twf_action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PURGE
	} twf_state_t;

	typedef struct packed {
		logic latch;
		logic exec;
		logic lim_load;
		logic pop;
		logic load_out;
	} twf_cmd_t;

	typedef struct packed {
		logic is_purge;
		logic pop_ok;
	} twf_sts_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
		return (i == PTR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

// ----- design/twf_req_if.sv -----
interface twf_req_if import twf_pkg::*;;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [63:0] stamp_in;
	logic signed [63:0] now_time;

	modport source (output valid, action, stamp_in, now_time, input ready);
	modport sink (input valid, action, stamp_in, now_time, output ready);
endinterface

// ----- design/twf_rsp_if.sv -----
interface twf_rsp_if import twf_pkg::*;;
	logic               valid;
	logic               ready;
	logic               ok;
	logic signed [63:0] stamp_out;
	logic [CNT_W-1:0]   occupancy;
	logic [CNT_W-1:0]   removed;

	modport source (output valid, ok, stamp_out, occupancy, removed, input ready);
	modport sink (input valid, ok, stamp_out, occupancy, removed, output ready);
endinterface

// ----- design/twf_ctrl.sv -----
module twf_ctrl import twf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_ready,
	input  twf_sts_t sts,
	output logic     in_ready,
	output logic     out_valid,
	output twf_cmd_t cmd
);

	twf_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.latch) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = sts.is_purge ? ST_PURGE : ST_IDLE;
			end
			ST_PURGE: begin
				if (!sts.pop_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				cmd.latch = in_valid && in_ready;
			end
			ST_EXEC: begin
				cmd.lim_load = sts.is_purge;
				cmd.exec = !sts.is_purge;
				cmd.load_out = !sts.is_purge;
			end
			ST_PURGE: begin
				cmd.pop = sts.pop_ok;
				cmd.load_out = !sts.pop_ok;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/twf_dp.sv -----
module twf_dp import twf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  twf_cmd_t            cmd,
	input  logic [1:0]          action,
	input  logic [STAMP_W-1:0]  stamp_in,
	input  logic [STAMP_W-1:0]  now_time,
	input  logic                cfg_we,
	input  logic [WIN_W-1:0]    cfg_wdata,
	output twf_sts_t            sts,
	output logic                ok,
	output logic [STAMP_W-1:0]  stamp_out,
	output logic [CNT_W-1:0]    occupancy,
	output logic [CNT_W-1:0]    removed
);

	logic [STAMP_W-1:0] mem [DEPTH];
	logic [STAMP_W-1:0] rd_data_q;
	twf_action_t        action_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] now_q;
	logic [WIN_W-1:0]   window_q;
	logic [STAMP_W-1:0] limit_q;
	logic               limit_ok_q;
	logic [CNT_W-1:0]   removed_q;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [PTR_W-1:0]   tail_q, tail_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               ok_q;
	logic [STAMP_W-1:0] stamp_out_q;
	logic [CNT_W-1:0]   occupancy_q;
	logic [CNT_W-1:0]   removed_out_q;
	logic               empty, full;
	logic               mem_we;
	logic               res_ok;
	logic [STAMP_W-1:0] res_stamp;
	logic [STAMP_W-1:0] now_ob;

	assign empty = (count_q == '0);
	assign full = (count_q == CNT_W'(DEPTH));
	assign now_ob = now_q ^ SIGN_MASK;

	assign sts.is_purge = (action_q == ACT_PURGE);
	assign sts.pop_ok = !empty && limit_ok_q && ((rd_data_q ^ SIGN_MASK) < limit_q);

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		mem_we = 1'b0;
		res_ok = 1'b0;
		res_stamp = '0;
		if (cmd.exec) begin
			case (action_q)
				ACT_ENQ: begin
					if (!full) begin
						mem_we = 1'b1;
						tail_d = ring_next(tail_q);
						count_d = count_q + 1'b1;
						res_ok = 1'b1;
					end
				end
				ACT_DEQ: begin
					if (!empty) begin
						head_d = ring_next(head_q);
						count_d = count_q - 1'b1;
						res_ok = 1'b1;
						res_stamp = rd_data_q;
					end
				end
				ACT_PEEK: begin
					if (!empty) begin
						res_ok = 1'b1;
						res_stamp = rd_data_q;
					end
				end
				default: begin
					res_ok = 1'b1;
				end
			endcase
		end else if (cmd.pop) begin
			head_d = ring_next(head_q);
			count_d = count_q - 1'b1;
		end else if (cmd.load_out) begin
			res_ok = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= stamp_q;
		end
		rd_data_q <= mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			window_q <= WINDOW_RESET;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= twf_action_t'(action);
			stamp_q <= stamp_in;
			now_q <= now_time;
		end
		if (cmd.lim_load) begin
			limit_ok_q <= now_ob >= {{(STAMP_W-WIN_W){1'b0}}, window_q};
			limit_q <= now_ob - {{(STAMP_W-WIN_W){1'b0}}, window_q};
			removed_q <= '0;
		end else if (cmd.pop) begin
			removed_q <= removed_q + 1'b1;
		end
		if (cmd.load_out) begin
			ok_q <= res_ok;
			stamp_out_q <= res_stamp;
			occupancy_q <= count_d;
			removed_out_q <= cmd.exec ? '0 : removed_q;
		end
	end

	assign ok = ok_q;
	assign stamp_out = stamp_out_q;
	assign occupancy = occupancy_q;
	assign removed = removed_out_q;

endmodule

// ----- design/timestamp_window_fifo_core.sv -----
// Timestamp window queue: a ring of signed 64-bit timestamps for
// sliding-window rate tracking.
// req channel: one beat carries action (enqueue, dequeue, peek, purge),
// stamp_in for enqueue and now_time for purge.
// rsp channel: one beat per request with ok, stamp_out, occupancy and
// removed. Results come back in request order.
// cfg_we/cfg_wdata write window_length; write it only while idle.
// Enqueue, dequeue and peek run in the exec state and their result is
// registered; a purge loads the limit in the exec state, then the purge
// loop pops one entry per cycle through the single memory read port.
// One request is in flight at a time: no new request is taken until the
// last one has its result in the output register.
// The result sits in an output register; a stalled rsp holds its beat and
// req.ready stays low until that beat leaves, though a new request is taken
// in the same cycle that the waiting beat is taken.
// Reset empties the queue and sets window_length to 1000; the store needs
// no clearing, since a slot is read only after it was written.
module timestamp_window_fifo_core import twf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	twf_req_if.sink          req,
	twf_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [WIN_W-1:0] cfg_wdata
);

	twf_cmd_t cmd;
	twf_sts_t sts;

	twf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	twf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (req.action),
		.stamp_in  (req.stamp_in),
		.now_time  (req.now_time),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.ok        (rsp.ok),
		.stamp_out (rsp.stamp_out),
		.occupancy (rsp.occupancy),
		.removed   (rsp.removed)
	);

endmodule

// ----- design/twf_chk.sv -----
module twf_chk import twf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_ok,
	input logic [STAMP_W-1:0] rsp_stamp_out,
	input logic [CNT_W-1:0]   rsp_occupancy,
	input logic [CNT_W-1:0]   rsp_removed
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stamp_out)
			&& $stable(rsp_occupancy) && $stable(rsp_removed) && $stable(rsp_ok))
		else $error("rsp beat changed while stalled");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_occupancy <= CNT_W'(DEPTH) && rsp_removed <= CNT_W'(DEPTH))
		else $error("occupancy or removed count beyond depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_stamp_out == '0 && rsp_removed == '0)
		else $error("failed action reports data");

	a_purge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_removed != '0 |-> rsp_ok && rsp_stamp_out == '0)
		else $error("purge result malformed");

	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while result stalled");

endmodule

bind timestamp_window_fifo_core twf_chk u_twf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_ok        (rsp.ok),
	.rsp_stamp_out (rsp.stamp_out),
	.rsp_occupancy (rsp.occupancy),
	.rsp_removed   (rsp.removed)
);

// ----- tb/sv/tb_timestamp_window_fifo_core.sv -----
module tb_timestamp_window_fifo_core;
	import twf_pkg::*;

	localparam logic signed [63:0] STAMP_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] STAMP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam int STALL_LIMIT = 4000;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		logic               ok;
		logic signed [63:0] stamp;
		logic [CNT_W-1:0]   occ;
		logic [CNT_W-1:0]   removed;
	} answer_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [WIN_W-1:0] cfg_wdata;

	twf_req_if req_ch ();
	twf_rsp_if rsp_ch ();

	timestamp_window_fifo_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic signed [63:0] held_stamps[$];
	logic [WIN_W-1:0]   window_len;
	answer_t            pending_answers[$];

	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int          mismatches;
	int          answers_checked;
	int          requests_sent;
	int          action_count[4];
	int          refused_enqueues;
	int          purged_total;
	int          window_writes;
	int          quiet_cycles;

	always #4 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic predict_answer(input twf_action_t act, input logic signed [63:0] stamp,
			input logic signed [63:0] now);
		answer_t a;
		logic signed [64:0] limit;
		a.ok = 1'b0;
		a.stamp = '0;
		a.removed = '0;
		action_count[act]++;
		case (act)
			ACT_ENQ: begin
				if (held_stamps.size() < DEPTH) begin
					held_stamps.push_back(stamp);
					a.ok = 1'b1;
				end else begin
					refused_enqueues++;
				end
			end
			ACT_DEQ: begin
				if (held_stamps.size() != 0) begin
					a.stamp = held_stamps.pop_front();
					a.ok = 1'b1;
				end
			end
			ACT_PEEK: begin
				if (held_stamps.size() != 0) begin
					a.stamp = held_stamps[0];
					a.ok = 1'b1;
				end
			end
			default: begin
				a.ok = 1'b1;
				limit = $signed({now[63], now}) - $signed({33'd0, window_len});
				while (held_stamps.size() != 0 &&
						$signed({held_stamps[0][63], held_stamps[0]}) < limit) begin
					void'(held_stamps.pop_front());
					a.removed = a.removed + 1'b1;
				end
				purged_total += a.removed;
			end
		endcase
		a.occ = CNT_W'(held_stamps.size());
		pending_answers.push_back(a);
	endtask

	task automatic send_beat(input twf_action_t act, input logic signed [63:0] stamp,
			input logic signed [63:0] now);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.stamp_in <= stamp;
		req_ch.now_time <= now;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		requests_sent++;
		predict_answer(act, stamp, now);
	endtask

	task automatic set_window_length(input logic [WIN_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_len = value;
		window_writes++;
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch on %s at answer %0d: got %h, want %h",
				field, answers_checked, got, want);
	endtask

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unrequested beat", rsp_ch.stamp_out, '0);
			end else begin
				want = pending_answers.pop_front();
				if (rsp_ch.ok !== want.ok)
					report_mismatch("ok", rsp_ch.ok, want.ok);
				if (rsp_ch.stamp_out !== want.stamp)
					report_mismatch("stamp_out", rsp_ch.stamp_out, want.stamp);
				if (rsp_ch.occupancy !== want.occ)
					report_mismatch("occupancy", rsp_ch.occupancy, want.occ);
				if (rsp_ch.removed !== want.removed)
					report_mismatch("removed", rsp_ch.removed, want.removed);
			end
			answers_checked++;
		end
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d answers outstanding",
				STALL_LIMIT, pending_answers.size());
			$display("tb_timestamp_window_fifo_core NOT OK");
			$finish;
		end
	end

	task automatic test_directed();
		send_beat(ACT_PEEK, rand64(), rand64());
		send_beat(ACT_DEQ, rand64(), rand64());
		send_beat(ACT_PURGE, rand64(), 64'sd0);
		send_beat(ACT_ENQ, STAMP_MIN, rand64());
		send_beat(ACT_ENQ, -64'sd1, rand64());
		send_beat(ACT_ENQ, 64'sd0, rand64());
		send_beat(ACT_ENQ, 64'sd5000, rand64());
		send_beat(ACT_ENQ, STAMP_MAX, rand64());
		send_beat(ACT_PEEK, rand64(), rand64());
		send_beat(ACT_PURGE, rand64(), STAMP_MIN);
		send_beat(ACT_PURGE, rand64(), STAMP_MIN + 64'sd999);
		send_beat(ACT_PURGE, rand64(), STAMP_MIN + 64'sd1001);
		send_beat(ACT_PURGE, rand64(), 64'sd999);
		send_beat(ACT_PURGE, rand64(), 64'sd1000);
		send_beat(ACT_PURGE, rand64(), 64'sd6000);
		send_beat(ACT_DEQ, rand64(), rand64());
		send_beat(ACT_PEEK, rand64(), rand64());
		send_beat(ACT_PURGE, rand64(), STAMP_MAX);
		send_beat(ACT_DEQ, rand64(), rand64());
		send_beat(ACT_DEQ, rand64(), rand64());
		send_beat(ACT_PEEK, rand64(), rand64());
		send_beat(ACT_ENQ, 64'shAAAA_AAAA_AAAA_AAAA, 64'sh5555_5555_5555_5555);
		send_beat(ACT_ENQ, 64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA);
		send_beat(ACT_DEQ, rand64(), rand64());
		send_beat(ACT_DEQ, rand64(), rand64());
	endtask

	task automatic test_full_ring();
		int fill;
		logic signed [63:0] t;
		fill = DEPTH - held_stamps.size();
		t = 0;
		repeat (fill) begin
			t = t + $urandom_range(1, 100);
			send_beat(ACT_ENQ, t, rand64());
		end
		send_beat(ACT_ENQ, rand64(), rand64());
		send_beat(ACT_PEEK, rand64(), rand64());
		send_beat(ACT_PURGE, rand64(), STAMP_MAX);
		repeat (12) begin
			t = t + $urandom_range(1, 100);
			send_beat(ACT_ENQ, t, rand64());
		end
		repeat (6) send_beat(ACT_DEQ, rand64(), rand64());
		send_beat(ACT_PEEK, rand64(), rand64());
	endtask

	task automatic test_window_extremes();
		set_window_length('0);
		send_beat(ACT_ENQ, 64'sd10, rand64());
		send_beat(ACT_ENQ, 64'sd11, rand64());
		send_beat(ACT_PURGE, rand64(), 64'sd10);
		send_beat(ACT_PURGE, rand64(), 64'sd11);
		send_beat(ACT_PURGE, rand64(), STAMP_MAX);
		set_window_length('1);
		send_beat(ACT_ENQ, STAMP_MIN, rand64());
		send_beat(ACT_ENQ, STAMP_MIN + 64'sd5, rand64());
		send_beat(ACT_PURGE, rand64(), STAMP_MIN);
		send_beat(ACT_PURGE, rand64(), STAMP_MIN + 64'sd4294967295 + 64'sd5);
		send_beat(ACT_PURGE, rand64(), STAMP_MIN + 64'sd4294967295 + 64'sd6);
		send_beat(ACT_PURGE, rand64(), STAMP_MAX);
		send_beat(ACT_PEEK, rand64(), rand64());
	endtask

	task automatic test_sliding_window(input int n_items, input logic [WIN_W-1:0] win,
			input logic signed [63:0] base);
		int unsigned r;
		int unsigned step_max;
		logic signed [63:0] track_now;
		set_window_length(win);
		track_now = base;
		step_max = win / 100 + 2;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_beat(ACT_ENQ, track_now - $urandom_range(0, 3), rand64());
				track_now = track_now + $urandom_range(0, step_max);
			end else if (r < 62) begin
				send_beat(ACT_PURGE, rand64(), track_now + $urandom_range(0, step_max));
			end else if (r < 72) begin
				send_beat(ACT_DEQ, rand64(), rand64());
			end else if (r < 82) begin
				send_beat(ACT_PEEK, rand64(), rand64());
			end else if (r < 88) begin
				send_beat(ACT_PURGE, rand64(),
					track_now + win - $urandom_range(0, 4 * step_max));
			end else begin
				send_beat(twf_action_t'($urandom_range(0, 3)), rand64(), rand64());
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_ENQ;
		req_ch.stamp_in = '0;
		req_ch.now_time = '0;
		rsp_ch.ready = 1'b0;
		window_len = WINDOW_RESET;
		mismatches = 0;
		answers_checked = 0;
		requests_sent = 0;
		action_count = '{default: 0};
		refused_enqueues = 0;
		purged_total = 0;
		window_writes = 0;
		quiet_cycles = 0;
		src_idle_pct = 28;
		sink_idle_pct = 49;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_ring();
		test_window_extremes();
		test_sliding_window(550, WIN_W'($urandom_range(500, 5000)), STAMP_MIN + 64'sd16);

		src_idle_pct = 49;
		sink_idle_pct = 28;
		test_sliding_window(550, $urandom | 32'h8000_0000, STAMP_MAX - (64'sd1 <<< 40));

		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_sliding_window(550, WIN_W'($urandom_range(1, 20000)), $signed(rand64()) >>> 2);

		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run: %0d requests (enq %0d, deq %0d, peek %0d, purge %0d), %0d answers checked",
			requests_sent, action_count[ACT_ENQ], action_count[ACT_DEQ],
			action_count[ACT_PEEK], action_count[ACT_PURGE], answers_checked);
		$display("run: %0d entries purged, %0d enqueues refused when full, %0d window writes",
			purged_total, refused_enqueues, window_writes);
		if (mismatches == 0)
			$display("tb_timestamp_window_fifo_core OK");
		else
			$display("tb_timestamp_window_fifo_core NOT OK");
		$finish;
	end

endmodule
